/* rtl/cpa_pkg.sv */
package cpa_pkg;

	localparam int ADDR_W  = 48;
	localparam int COUNT_W = 11;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;

	localparam int FREE_BIT = 0;
	localparam int LAST_BIT = 1;

	localparam logic [1:0] DESC_FREE = 2'b01;

	localparam logic CFG_HEAP_BASE   = 1'b0;
	localparam logic CFG_PAGES_AVAIL = 1'b1;

	localparam logic [COUNT_W-1:0] PAGES_AVAIL_RST = 11'd1024;

	typedef struct packed {
		logic               command;
		logic [COUNT_W-1:0] page_count;
		logic [ADDR_W-1:0]  address;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] granted_address;
	} out_word_t;

endpackage

/* rtl/cpa_page_div.sv */
module cpa_page_div #(
	parameter int NUM_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cpa_pkg::ADDR_W-1:0]  dividend,
	output logic                        done,
	output logic [cpa_pkg::ADDR_W-1:0]  quotient
);

	localparam longint unsigned SPAN = 64'(NUM_PAGES) * 64'(PAGE_BYTES);
	localparam int X_W     = $clog2(SPAN);
	localparam int SH_W    = $clog2(PAGE_BYTES);
	localparam int SHIFT   = X_W + SH_W;
	localparam int RECIP_W = X_W + 2;
	localparam int PROD_W  = X_W + RECIP_W;
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + 64'(PAGE_BYTES) - 64'd1)
	                                    / 64'(PAGE_BYTES);
	localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(RECIP);

	logic                       vld_s1;
	logic                       vld_s2;
	logic                       over_q;
	logic [X_W-1:0]             offset_s1;
	logic [PROD_W-1:0]          prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	// exact for every offset below 2**X_W; larger offsets lie past the last page
	always_ff @(posedge clk) begin
		if (start) begin
			offset_s1 <= dividend[X_W-1:0];
			over_q    <= |dividend[cpa_pkg::ADDR_W-1:X_W];
		end
		if (vld_s1) begin
			prod_s2 <= PROD_W'(offset_s1) * PROD_W'(RECIP_M);
		end
	end

	assign done     = vld_s2;
	assign quotient = over_q ? '1 : cpa_pkg::ADDR_W'(prod_s2[PROD_W-1:SHIFT]);

endmodule

/* rtl/contiguous_page_allocator_top.sv */
// First-fit contiguous page allocator. One 2-bit descriptor per page (free, last of run) lives
// in a single on-chip memory with one write and one registered read port. After reset a
// clearing pass marks every page free, with in_ready low. An allocate streams the descriptors
// from page 0 at one per cycle until it finds the run, then writes the run back at one page
// per cycle and adds the base. A zero page count goes straight to the response. A free maps
// its address to a page with a reciprocal multiply by PAGE_BYTES, then walks the run at one
// page per cycle. One word is in work at a time; a finished result sits in the output register
// and the next word is taken meanwhile.
module contiguous_page_allocator_top #(
	parameter int NUM_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  cpa_pkg::in_word_t           in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output cpa_pkg::out_word_t          out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [cpa_pkg::ADDR_W-1:0]  cfg_data
);

	localparam int IDX_W  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CNT_W  = $clog2(NUM_PAGES + 1);
	localparam int CMP_W  = (CNT_W > cpa_pkg::COUNT_W) ? CNT_W : cpa_pkg::COUNT_W;
	localparam int SUM_W  = ((IDX_W > cpa_pkg::COUNT_W) ? IDX_W : cpa_pkg::COUNT_W) + 1;
	localparam int PB_W   = $clog2(PAGE_BYTES + 1);
	localparam int PROD_W = IDX_W + PB_W;

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_SCAN  = 9'b000000100,
		S_MARK  = 9'b000001000,
		S_MUL   = 9'b000010000,
		S_ADD   = 9'b000100000,
		S_DIV   = 9'b001000000,
		S_WALK  = 9'b010000000,
		S_RESP  = 9'b100000000
	} state_t;

	state_t                       state_q;
	logic [IDX_W-1:0]             clr_idx_q;
	logic [cpa_pkg::ADDR_W-1:0]   heap_base_q;
	logic [cpa_pkg::COUNT_W-1:0]  pages_avail_q;
	logic [cpa_pkg::COUNT_W-1:0]  want_q;
	logic [cpa_pkg::COUNT_W-1:0]  run_q;
	logic [CNT_W-1:0]             rd_ptr_q;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	logic [1:0]                   rd_data_s1;
	logic [IDX_W-1:0]             first_q;
	logic [IDX_W-1:0]             last_q;
	logic [IDX_W-1:0]             wr_ptr_q;
	logic                         walk_head_q;
	logic [PROD_W-1:0]            prod_s1;
	cpa_pkg::out_word_t           res_q;
	logic                         out_valid_q;
	cpa_pkg::out_word_t           out_data_q;

	logic [1:0]                   page_mem [NUM_PAGES];

	logic [CNT_W-1:0]             n_pages;
	logic                         accept_in;
	logic                         out_free;
	logic [cpa_pkg::COUNT_W-1:0]  run_next;
	logic                         scan_hit;
	logic                         scan_miss;
	logic                         walk_skip;
	logic                         walk_end;
	logic                         rd_en;
	logic [SUM_W-1:0]             first_sum;
	logic                         mem_we;
	logic [IDX_W-1:0]             mem_waddr;
	logic [1:0]                   mem_wdata;
	logic                         below_base;
	logic                         div_start;
	logic                         div_done;
	logic [cpa_pkg::ADDR_W-1:0]   div_quo;
	logic                         beyond_range;

	assign n_pages = (CMP_W'(pages_avail_q) > CMP_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
	                                                               : CNT_W'(pages_avail_q);

	assign accept_in = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	assign run_next  = run_q + cpa_pkg::COUNT_W'(1);
	assign scan_hit  = rd_vld_s1 && rd_data_s1[cpa_pkg::FREE_BIT] && (run_next == want_q);
	assign scan_miss = !rd_vld_s1 && (rd_ptr_q >= n_pages);
	assign walk_skip = rd_vld_s1 && walk_head_q && rd_data_s1[cpa_pkg::FREE_BIT];
	assign walk_end  = rd_vld_s1 && (walk_skip || rd_data_s1[cpa_pkg::LAST_BIT] ||
	                   (CNT_W'(rd_idx_s1) + CNT_W'(1) == n_pages));

	assign rd_en = (((state_q == S_SCAN) && !scan_hit) || ((state_q == S_WALK) && !walk_end))
	               && (rd_ptr_q < n_pages);

	assign first_sum = SUM_W'(rd_idx_s1) + SUM_W'(1) - SUM_W'(want_q);

	assign below_base   = in_data.address < heap_base_q;
	assign div_start    = accept_in && (in_data.command == cpa_pkg::CMD_FREE) && !below_base;
	assign beyond_range = div_quo >= cpa_pkg::ADDR_W'(n_pages);

	cpa_page_div #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_data.address - heap_base_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = cpa_pkg::DESC_FREE;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = wr_ptr_q;
				mem_wdata = '0;
				mem_wdata[cpa_pkg::LAST_BIT] = (wr_ptr_q == last_q);
			end
			S_WALK: begin
				mem_we    = rd_vld_s1 && !walk_skip;
				mem_waddr = rd_idx_s1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			page_mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= page_mem[rd_ptr_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q   <= '0;
			pages_avail_q <= cpa_pkg::PAGES_AVAIL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cpa_pkg::CFG_HEAP_BASE:   heap_base_q   <= cfg_data;
				cpa_pkg::CFG_PAGES_AVAIL: pages_avail_q <= cfg_data[cpa_pkg::COUNT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_idx_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if ((state_q == S_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_W'(NUM_PAGES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept_in) begin
						unique case (in_data.command)
							cpa_pkg::CMD_ALLOC: begin
								state_q <= (in_data.page_count == '0) ? S_RESP : S_SCAN;
							end
							cpa_pkg::CMD_FREE: begin
								state_q <= below_base ? S_RESP : S_DIV;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_hit) begin
						state_q <= S_MARK;
					end else if (scan_miss) begin
						state_q <= S_RESP;
					end
				end
				S_MARK: begin
					if (wr_ptr_q == last_q) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_RESP;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= beyond_range ? S_RESP : S_WALK;
					end
				end
				S_WALK: begin
					if (walk_end || scan_miss) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_ptr_q  <= rd_ptr_q + CNT_W'(1);
			rd_idx_s1 <= rd_ptr_q[IDX_W-1:0];
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept_in) begin
					want_q                <= in_data.page_count;
					run_q                 <= '0;
					rd_ptr_q              <= '0;
					walk_head_q           <= 1'b1;
					res_q.granted_address <= '0;
					if (in_data.command == cpa_pkg::CMD_ALLOC) begin
						res_q.status <= cpa_pkg::ST_NOSPACE;
					end else begin
						res_q.status <= cpa_pkg::ST_IGNORED;
					end
				end
			end
			S_SCAN: begin
				if (rd_vld_s1) begin
					run_q <= rd_data_s1[cpa_pkg::FREE_BIT] ? run_next : '0;
				end
				if (scan_hit) begin
					first_q  <= first_sum[IDX_W-1:0];
					wr_ptr_q <= first_sum[IDX_W-1:0];
					last_q   <= rd_idx_s1;
				end
			end
			S_MARK: begin
				wr_ptr_q <= wr_ptr_q + IDX_W'(1);
			end
			S_MUL: begin
				prod_s1 <= PROD_W'(first_q) * PROD_W'(PAGE_BYTES);
			end
			S_ADD: begin
				res_q.granted_address <= heap_base_q + cpa_pkg::ADDR_W'(prod_s1);
				res_q.status          <= cpa_pkg::ST_DONE;
			end
			S_DIV: begin
				if (div_done) begin
					rd_ptr_q <= div_quo[CNT_W-1:0];
					if (!beyond_range) begin
						res_q.status <= cpa_pkg::ST_DONE;
					end
				end
			end
			S_WALK: begin
				if (rd_vld_s1) begin
					walk_head_q <= 1'b0;
				end
				if (walk_skip) begin
					res_q.status <= cpa_pkg::ST_IGNORED;
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_data_q <= res_q;
				end
			end
			default: begin
				walk_head_q <= walk_head_q;
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign cfg_ready = 1'b1;

endmodule

/* dv/contiguous_page_allocator_checker.sv */
`timescale 1ns / 1ps

module contiguous_page_allocator_checker #(
	parameter int NUM_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  cpa_pkg::in_word_t           in_data,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  cpa_pkg::out_word_t          out_data,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [cpa_pkg::ADDR_W-1:0]  cfg_data,
	output int unsigned                 outstanding,
	output int unsigned                 failures
);

	import cpa_pkg::*;

	logic [1:0]         page_desc [NUM_PAGES];
	logic [ADDR_W-1:0]  heap_base;
	logic [COUNT_W-1:0] pages_avail;
	out_word_t          due_results [$];
	out_word_t          oldest;
	out_word_t          predicted;
	int unsigned        mismatch_total = 0;

	assign failures = mismatch_total;

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
		mismatch_total++;
	endtask

	function automatic int unsigned managed_count();
		return (pages_avail > NUM_PAGES) ? NUM_PAGES : int'(pages_avail);
	endfunction

	function automatic void grant_run(input logic [COUNT_W-1:0] want, output logic [1:0] st,
		output logic [ADDR_W-1:0] granted);
		int unsigned n;
		int unsigned run;
		int unsigned i;
		int unsigned first;
		bit          found;
		logic [63:0] sum;
		n = managed_count();
		run = 0;
		first = 0;
		found = 1'b0;
		st = ST_NOSPACE;
		granted = '0;
		if (want == 0)
			return;
		for (i = 0; i < n && !found; i++) begin
			if (page_desc[i][FREE_BIT]) begin
				run++;
				if (run == want) begin
					found = 1'b1;
					first = i + 1 - want;
				end
			end else begin
				run = 0;
			end
		end
		if (!found)
			return;
		for (i = first; i < first + want; i++)
			page_desc[i][FREE_BIT] = 1'b0;
		page_desc[first + want - 1][LAST_BIT] = 1'b1;
		sum = {16'b0, heap_base} + 64'(first) * 64'(PAGE_BYTES);
		granted = sum[ADDR_W-1:0];
		st = ST_DONE;
	endfunction

	function automatic logic [1:0] release_run(input logic [ADDR_W-1:0] addr);
		int unsigned n;
		int unsigned j;
		logic [63:0] idx;
		bit          hit_last;
		n = managed_count();
		if (addr < heap_base)
			return ST_IGNORED;
		idx = {16'b0, addr - heap_base} / 64'(PAGE_BYTES);
		if (idx >= 64'(n))
			return ST_IGNORED;
		if (page_desc[idx][FREE_BIT])
			return ST_IGNORED;
		j = idx[31:0];
		hit_last = 1'b0;
		while (j < n && !hit_last) begin
			hit_last = page_desc[j][LAST_BIT];
			page_desc[j] = DESC_FREE;
			j++;
		end
		return ST_DONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_PAGES; k++)
				page_desc[k] = DESC_FREE;
			heap_base = '0;
			pages_avail = PAGES_AVAIL_RST;
			due_results.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected word", 64'(out_data), 64'd0);
				end else begin
					oldest = due_results.pop_front();
					if (out_data.status !== oldest.status)
						report_mismatch("status", 64'(out_data.status), 64'(oldest.status));
					if (out_data.granted_address !== oldest.granted_address)
						report_mismatch("granted_address", 64'(out_data.granted_address),
							64'(oldest.granted_address));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_HEAP_BASE)
					heap_base = cfg_data;
				else
					pages_avail = cfg_data[COUNT_W-1:0];
			end
			if (in_valid && in_ready) begin
				predicted.granted_address = '0;
				if (in_data.command == CMD_ALLOC)
					grant_run(in_data.page_count, predicted.status, predicted.granted_address);
				else
					predicted.status = release_run(in_data.address);
				due_results.push_back(predicted);
			end
			outstanding <= due_results.size();
		end
	end

endmodule

/* dv/tb_contiguous_page_allocator_top.sv */
`timescale 1ns / 1ps

module tb_contiguous_page_allocator_top;

	import cpa_pkg::*;

	localparam int NUM_PAGES  = 1024;
	localparam int PAGE_BYTES = 4096;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_word_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_word_t         out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic              cfg_index = CFG_HEAP_BASE;
	logic [ADDR_W-1:0] cfg_data = '0;

	int unsigned       outstanding;
	int unsigned       failures;

	bit                calm = 1'b0;
	int unsigned       ready_left = 0;
	logic [ADDR_W-1:0] cur_base = '0;
	int unsigned       cur_pages = NUM_PAGES;
	logic              sent_cmds [$];
	logic [ADDR_W-1:0] live_runs [$];

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	contiguous_page_allocator_top #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	contiguous_page_allocator_checker #(
		.NUM_PAGES (NUM_PAGES),
		.PAGE_BYTES(PAGE_BYTES)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.outstanding(outstanding),
		.failures   (failures)
	);

	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (ready_left != 0) begin
			ready_left--;
		end else if (out_ready && $urandom_range(0, 2) == 0) begin
			out_ready <= 1'b0;
			ready_left = $urandom_range(0, 10);
		end else begin
			out_ready <= 1'b1;
			ready_left = $urandom_range(1, 30);
		end
	end

	// track granted runs so that most frees hit a live run
	always @(posedge clk) begin
		if (out_valid && out_ready && sent_cmds.size() != 0) begin
			if (sent_cmds.pop_front() == CMD_ALLOC && out_data.status == ST_DONE)
				live_runs.push_back(out_data.granted_address);
		end
		if (in_valid && in_ready)
			sent_cmds.push_back(in_data.command);
	end

	function automatic logic [ADDR_W-1:0] any_addr();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[ADDR_W-1:0];
	endfunction

	task automatic put_word(input logic cmd, input logic [COUNT_W-1:0] cnt,
		input logic [ADDR_W-1:0] addr);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.command <= cmd;
		in_data.page_count <= cnt;
		in_data.address <= addr;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [ADDR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_config(input logic [ADDR_W-1:0] base, input logic [ADDR_W-1:0] pages);
		drain();
		set_reg(CFG_HEAP_BASE, base);
		set_reg(CFG_PAGES_AVAIL, pages);
		cfg_valid <= 1'b0;
		cur_base = base;
		cur_pages = 32'(pages[COUNT_W-1:0]);
		live_runs.delete();
	endtask

	task automatic run_phase(input logic [ADDR_W-1:0] base, input int unsigned pages,
		input int unsigned total);
		int unsigned        i;
		int unsigned        n;
		int unsigned        k;
		int unsigned        r;
		logic [ADDR_W-1:0]  a;
		logic [COUNT_W-1:0] c;
		apply_config(base, ADDR_W'(pages));
		n = (cur_pages > NUM_PAGES) ? NUM_PAGES : cur_pages;
		for (i = 0; i < total; i++) begin
			if (i == total / 2)
				drain();
			r = $urandom_range(0, 99);
			c = COUNT_W'($urandom_range(0, 2047));
			a = any_addr();
			if (r < 45) begin
				r = $urandom_range(0, 99);
				if (r < 5)
					c = '0;
				else if (r < 75)
					c = COUNT_W'($urandom_range(1, 8));
				else if (r < 90)
					c = COUNT_W'($urandom_range(1, n + 1));
				put_word(CMD_ALLOC, c, a);
			end else if (r < 80 && live_runs.size() != 0) begin
				k = $urandom_range(0, live_runs.size() - 1);
				a = live_runs[k];
				live_runs.delete(k);
				if ($urandom_range(0, 3) == 0)
					a = a + ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
				put_word(CMD_FREE, c, a);
			end else begin
				case ($urandom_range(0, 2))
					0: ;
					1: a = cur_base + ADDR_W'($urandom_range(0, n + 1)) * ADDR_W'(PAGE_BYTES)
						+ ADDR_W'($urandom_range(0, PAGE_BYTES - 1));
					default: a = cur_base - ADDR_W'($urandom_range(1, 5000));
				endcase
				put_word(CMD_FREE, c, a);
			end
		end
	endtask

	initial begin
		#60_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		put_word(CMD_ALLOC, 11'd0, 48'h0);
		put_word(CMD_ALLOC, 11'd1, 48'h0);
		put_word(CMD_ALLOC, 11'd3, 48'h0);
		put_word(CMD_ALLOC, 11'd1024, 48'h0);
		put_word(CMD_ALLOC, 11'h7FF, 48'h0);
		put_word(CMD_FREE, 11'd0, 48'h1123);
		put_word(CMD_FREE, 11'd0, 48'h2000);
		put_word(CMD_FREE, 11'd0, 48'h0);
		put_word(CMD_ALLOC, 11'd1024, 48'hFFFF_FFFF_FFFF);
		put_word(CMD_FREE, 11'h7FF, 48'h3000);
		put_word(CMD_FREE, 11'd0, 48'h1000);
		put_word(CMD_FREE, 11'd0, 48'h0);
		put_word(CMD_FREE, 11'd0, 48'h40_0000);
		put_word(CMD_FREE, 11'd0, 48'hFFFF_FFFF_FFFF);

		apply_config(48'hFFFF_FFFF_E000, 48'd16);
		put_word(CMD_ALLOC, 11'd2, 48'h0);
		put_word(CMD_ALLOC, 11'd1, 48'h0);
		put_word(CMD_FREE, 11'd0, 48'h100);
		put_word(CMD_FREE, 11'd0, 48'hFFFF_FFFF_E010);
		put_word(CMD_ALLOC, 11'd16, 48'h0);

		apply_config(48'h8000_0000_0000, 48'd0);
		put_word(CMD_ALLOC, 11'd1, 48'h0);
		put_word(CMD_FREE, 11'd0, 48'h8000_0000_0000);

		run_phase(any_addr(), 64, 70);
		run_phase('0, 1, 30);
		run_phase('1, 8, 40);
		run_phase(any_addr(), 2047, 40);
		run_phase(any_addr(), 1024, 30);
		run_phase(any_addr(), $urandom_range(2, 128), 80);
		calm = 1'b1;
		run_phase(any_addr(), 32, 110);

		drain();
		repeat (2 * NUM_PAGES + 64) @(posedge clk);
		if (failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
rtl/cpa_pkg.sv
rtl/cpa_page_div.sv
rtl/contiguous_page_allocator_top.sv
dv/contiguous_page_allocator_checker.sv
dv/tb_contiguous_page_allocator_top.sv
